>>> rtl/core/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the symmetric pair matrix block: command
// codes, fixed field widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package spm_pkg;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int IN_IDX_W  = 6;
  localparam int CFG_W     = 7;
  localparam int CNT_W     = 11;

  localparam logic [CFG_W-1:0] FACT_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX        = 11'd2047;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd3;

  // Row memory read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_FIRST,
    RD_SECOND,
    RD_ZERO,
    RD_NEXT
  } rd_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    latch_in;      // capture the accepted item
    logic    clear_all;     // drop the matrix, counter and open set
    rd_sel_e rd_sel;        // row read this cycle
    logic    wr_first;      // row of first index |= bit of second
    logic    wr_second;     // row of second index |= bit of first
    logic    wr_sweep;      // self-pair sweep write of the current row
    logic    sweep_init;    // restart the sweep at row zero
    logic    set_update;    // fold the read row into the open set
    logic    query_capture; // store the queried bit
    logic    load_out;      // load the result register
    logic    close_set;     // drop the open set after this result
  } spm_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             err;
    logic             self_pair;
    logic             last;
    logic             sweep_last;
  } spm_stat_t;

endpackage

>>> rtl/core/spm_dp.sv
// ----------------------------------------------------------------------------
// spm_dp
// Datapath: item and config registers, row memory with per-row valid bits,
// pair counter, open set state and the result register.
// ----------------------------------------------------------------------------
module spm_dp #(
  parameter int MAX_INDICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [spm_pkg::CMD_W-1:0]     command_i,
  input  logic [spm_pkg::IN_IDX_W-1:0]  first_index_i,
  input  logic [spm_pkg::IN_IDX_W-1:0]  second_index_i,
  input  logic                          last_in_set_i,
  input  spm_pkg::spm_ctrl_t            ctrl_i,
  output spm_pkg::spm_stat_t            stat_o,
  output logic                          conflict_o,
  output logic                          index_error_o,
  output logic [spm_pkg::CNT_W-1:0]     pair_total_o,
  output logic                          set_complete_o
);

  localparam int ROW_W  = MAX_INDICES;
  localparam int IDX_W  = $clog2(MAX_INDICES);
  localparam int NW_MIN = $clog2(MAX_INDICES + 1);
  localparam int NW     = (NW_MIN > spm_pkg::CFG_W) ? NW_MIN : spm_pkg::CFG_W;

  // Item and config registers
  logic [spm_pkg::CMD_W-1:0]    cmd_q;
  logic [spm_pkg::IN_IDX_W-1:0] f1_q, f2_q;
  logic                         last_q;
  logic [spm_pkg::CFG_W-1:0]    fact_count_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cmd_q  <= command_i;
      f1_q   <= first_index_i;
      f2_q   <= second_index_i;
      last_q <= last_in_set_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fact_count_q <= spm_pkg::FACT_COUNT_RST;
    end else if (cfg_we_i) begin
      fact_count_q <= cfg_wdata_i;
    end
  end

  // Range checks against the saturated count in use
  logic [NW-1:0]    fc_ext, n_use, f1_ext, f2_ext;
  logic             f1_bad, f2_bad, err;
  logic [IDX_W-1:0] addr_a, addr_b;

  always_comb begin
    fc_ext = NW'(fact_count_q);
    n_use  = (fc_ext > NW'(MAX_INDICES)) ? NW'(MAX_INDICES) : fc_ext;
    f1_ext = NW'(f1_q);
    f2_ext = NW'(f2_q);
    f1_bad = (f1_ext >= n_use);
    f2_bad = (f2_ext >= n_use);
    addr_a = f1_ext[IDX_W-1:0];
    addr_b = f2_ext[IDX_W-1:0];
    case (cmd_q)
      spm_pkg::CMD_ADD,
      spm_pkg::CMD_QUERY: err = f1_bad | f2_bad;
      spm_pkg::CMD_SET:   err = f1_bad;
      default:            err = 1'b0;
    endcase
  end

  // Mask of indices in use
  logic [ROW_W-1:0] mask_n;

  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      mask_n[i] = (NW'(i) < n_use);
    end
  end

  // Sweep row pointer
  logic [IDX_W-1:0] sweep_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sweep_init) begin
      sweep_q <= '0;
    end else if (ctrl_i.wr_sweep) begin
      sweep_q <= sweep_q + IDX_W'(1);
    end
  end

  // Row memory: one write and one registered read per cycle
  logic [ROW_W-1:0] row_mem_q [MAX_INDICES];
  logic [ROW_W-1:0] row_valid_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             rd_valid_q;
  logic [ROW_W-1:0] row_eff, bit_a, bit_b, wdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic             rd_en, wr_en;

  assign row_eff = rd_valid_q ? rd_data_q : '0;
  assign bit_a   = ROW_W'(1) << addr_a;
  assign bit_b   = ROW_W'(1) << addr_b;

  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    case (ctrl_i.rd_sel)
      spm_pkg::RD_FIRST:  raddr = addr_a;
      spm_pkg::RD_SECOND: raddr = addr_b;
      spm_pkg::RD_ZERO:   raddr = '0;
      spm_pkg::RD_NEXT:   raddr = sweep_q + IDX_W'(1);
      default:            rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en = ctrl_i.wr_first | ctrl_i.wr_second | ctrl_i.wr_sweep;
    waddr = sweep_q;
    wdata = row_eff | bit_a;
    if (ctrl_i.wr_first) begin
      waddr = addr_a;
      wdata = row_eff | bit_b;
    end else if (ctrl_i.wr_second) begin
      waddr = addr_b;
      wdata = row_eff | bit_a;
    end else if (sweep_q == addr_a) begin
      // the self-paired row takes every index in use
      wdata = row_eff | bit_a | mask_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= row_mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (ctrl_i.clear_all) begin
        row_valid_q <= '0;
      end else if (wr_en) begin
        row_valid_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid_q[raddr];
      end
    end
  end

  // Pair counter, saturating
  logic [spm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      cnt_inc;

  always_comb begin
    cnt_inc = (ctrl_i.wr_first & ~row_eff[addr_b]) |
              (ctrl_i.wr_sweep & ~row_eff[addr_a] & (sweep_q != addr_a));
    cnt_d = cnt_q;
    if (ctrl_i.clear_all) begin
      cnt_d = '0;
    end else if (cnt_inc && (cnt_q != spm_pkg::CNT_MAX)) begin
      cnt_d = cnt_q + spm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Open set: members and sticky conflict
  logic [ROW_W-1:0] set_members_q;
  logic             set_conflict_q;
  logic             set_hit;

  assign set_hit = |((set_members_q | bit_a) & row_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_members_q  <= '0;
      set_conflict_q <= 1'b0;
    end else if (ctrl_i.clear_all || ctrl_i.close_set) begin
      set_members_q  <= '0;
      set_conflict_q <= 1'b0;
    end else if (ctrl_i.set_update) begin
      set_members_q  <= set_members_q | bit_a;
      set_conflict_q <= set_conflict_q | set_hit;
    end
  end

  // Queried bit
  logic query_hit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.query_capture) begin
      query_hit_q <= row_eff[addr_b];
    end
  end

  // Result register
  logic conflict_d;

  always_comb begin
    case (cmd_q)
      spm_pkg::CMD_QUERY: conflict_d = query_hit_q & ~err;
      spm_pkg::CMD_SET:   conflict_d = set_conflict_q;
      default:            conflict_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      conflict_o     <= conflict_d;
      index_error_o  <= err;
      pair_total_o   <= cnt_q;
      set_complete_o <= (cmd_q == spm_pkg::CMD_SET) & last_q;
    end
  end

  // Status
  assign stat_o.cmd        = cmd_q;
  assign stat_o.err        = err;
  assign stat_o.self_pair  = (f1_q == f2_q);
  assign stat_o.last       = last_q;
  assign stat_o.sweep_last = (NW'(sweep_q) == (n_use - NW'(1)));

endmodule

>>> rtl/core/spm_ctrl.sv
// ----------------------------------------------------------------------------
// spm_ctrl
// Controller: sequences each command over the row memory port and owns the
// input ready and the result valid.
// ----------------------------------------------------------------------------
module spm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  spm_pkg::spm_stat_t stat_i,
  output spm_pkg::spm_ctrl_t ctrl_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_PAIR   = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = ~out_valid_q | out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.rd_sel = spm_pkg::RD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.latch_in = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.cmd == spm_pkg::CMD_CLEAR) begin
          ctrl_o.clear_all = 1'b1;
          state_d = ST_FINISH;
        end else if (stat_i.err) begin
          state_d = ST_FINISH;
        end else if ((stat_i.cmd == spm_pkg::CMD_ADD) && stat_i.self_pair) begin
          ctrl_o.rd_sel     = spm_pkg::RD_ZERO;
          ctrl_o.sweep_init = 1'b1;
          state_d = ST_SWEEP;
        end else begin
          ctrl_o.rd_sel = spm_pkg::RD_FIRST;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_FINISH;
        case (stat_i.cmd)
          spm_pkg::CMD_ADD: begin
            ctrl_o.wr_first = 1'b1;
            ctrl_o.rd_sel   = spm_pkg::RD_SECOND;
            state_d = ST_PAIR;
          end
          spm_pkg::CMD_QUERY: ctrl_o.query_capture = 1'b1;
          spm_pkg::CMD_SET:   ctrl_o.set_update    = 1'b1;
          default:            ctrl_o.query_capture = 1'b0;
        endcase
      end
      ST_PAIR: begin
        ctrl_o.wr_second = 1'b1;
        state_d = ST_FINISH;
      end
      ST_SWEEP: begin
        // write the current row while the next one is read
        ctrl_o.wr_sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_FINISH;
        end else begin
          ctrl_o.rd_sel = spm_pkg::RD_NEXT;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          ctrl_o.load_out  = 1'b1;
          ctrl_o.close_set = (stat_i.cmd == spm_pkg::CMD_SET) & stat_i.last;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/symmetric_pair_matrix_top.sv
// ----------------------------------------------------------------------------
// symmetric_pair_matrix_top
// Symmetric conflict bit matrix with pair counter and streamed set checking.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready_o is high only while the block is
// idle, and the result register frees the input side as soon as a result is
// loaded. Clear and out-of-range items go from execute to finish; query and
// set element read the first index's row; add of distinct indices reads and
// writes the first index's row, then the second's; add of an index paired
// with itself sweeps all N rows in use (N is the min of fact_count and
// MAX_INDICES). The row memory has one read and one write port: each row
// touched costs a read and a write, and the self-pair sweep streams one row
// per cycle. A result that is not taken stalls the block in its last step.
// Reset and the clear command empty the matrix at once (per-row valid bits).
// ----------------------------------------------------------------------------
module symmetric_pair_matrix_top #(
  parameter int MAX_INDICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [spm_pkg::CMD_W-1:0]     command_i,
  input  logic [spm_pkg::IN_IDX_W-1:0]  first_index_i,
  input  logic [spm_pkg::IN_IDX_W-1:0]  second_index_i,
  input  logic                          last_in_set_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          conflict_o,
  output logic                          index_error_o,
  output logic [spm_pkg::CNT_W-1:0]     pair_total_o,
  output logic                          set_complete_o
);

  spm_pkg::spm_ctrl_t ctrl;
  spm_pkg::spm_stat_t stat;

  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  spm_dp #(
    .MAX_INDICES (MAX_INDICES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .first_index_i  (first_index_i),
    .second_index_i (second_index_i),
    .last_in_set_i  (last_in_set_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .conflict_o     (conflict_o),
    .index_error_o  (index_error_o),
    .pair_total_o   (pair_total_o),
    .set_complete_o (set_complete_o)
  );

  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over an untaken result");

  // An accepted item keeps the input side closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // Clearing never overlaps a row write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear_all |-> !(ctrl.wr_first || ctrl.wr_second || ctrl.wr_sweep))
    else $error("clear and row write in the same cycle");

  // The result of a clear reports an empty counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.load_out && (stat.cmd == spm_pkg::CMD_CLEAR)) |=> (pair_total_o == '0))
    else $error("pair total not zero after clear");

endmodule
